// ===== hw/rtl/sdf_pkg.sv =====
// ----------------------------------------------------------------------------
// sdf_pkg - shared types and constants for the decimal field formatter
// Holds the classification codes, the queue item layout, the configuration
// bundle, the register indexes, ASCII codes and the powers-of-ten table.
// ----------------------------------------------------------------------------
`default_nettype none

package sdf_pkg;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_FIELD_WIDTH   = 2'd0;
    localparam logic [1:0] REG_SIGN_MODE     = 2'd1;
    localparam logic [1:0] REG_LEADING_ZEROS = 2'd2;

    // Sign mode codes.
    localparam logic [1:0] SIGN_NONE  = 2'd0;
    localparam logic [1:0] SIGN_MINUS = 2'd1;
    localparam logic [1:0] SIGN_BOTH  = 2'd2;

    // ASCII codes used in the field.
    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_MINUS = 8'h2D;
    localparam logic [7:0] ASCII_PLUS  = 8'h2B;
    localparam logic [7:0] ASCII_SPACE = 8'h20;

    // A 16-bit magnitude has at most five decimal digits.
    localparam int DIGITS     = 5;
    localparam int DIGIT_IDXW = 3;

    // Reciprocal of ten for a 16-bit dividend: q = (x * RECIP_TEN) >> RECIP_SHIFT.
    localparam logic [15:0] RECIP_TEN   = 16'hCCCD;
    localparam int          RECIP_SHIFT = 19;

    // Depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // Class of an item as decided by the front.
    typedef enum logic [1:0] {
        CLS_NORMAL   = 2'd0,
        CLS_NEG_OVER = 2'd1,
        CLS_POS_OVER = 2'd2
    } cls_t;

    // Back-end sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE    = 2'd0,
        ST_CONVERT = 2'd1,
        ST_EMIT    = 2'd2
    } state_t;

    // Decoded configuration shared by front and back.
    typedef struct packed {
        logic [3:0] width;     // clamped field width
        logic       has_sign;
        logic       plus;
        logic       lead;
    } cfg_t;

    // One classified item on its way to the back.
    typedef struct packed {
        cls_t        cls;
        logic        neg;
        logic [15:0] mag;
    } entry_t;

    // Powers of ten from 10^0 to 10^8.
    function automatic logic [27:0] pow10(input logic [3:0] e);
        logic [27:0] r;
        begin
            case (e)
                4'd0:    r = 28'd1;
                4'd1:    r = 28'd10;
                4'd2:    r = 28'd100;
                4'd3:    r = 28'd1000;
                4'd4:    r = 28'd10000;
                4'd5:    r = 28'd100000;
                4'd6:    r = 28'd1000000;
                4'd7:    r = 28'd10000000;
                4'd8:    r = 28'd100000000;
                default: r = 28'd100000000;
            endcase
            return r;
        end
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sdf_front.sv =====
// ----------------------------------------------------------------------------
// sdf_front - input classification
// Checks an incoming value against the field limits and hands the class,
// the sign and the magnitude to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sdf_front
    import sdf_pkg::*;
(
    input  wire cfg_t        cfg,
    input  wire logic        in_valid,
    input  wire logic [15:0] value,
    input  wire logic        q_full,
    output logic             push,
    output entry_t           entry
);

    logic [3:0]         lim_exp;
    logic [27:0]        lim;
    logic [27:0]        hi;
    logic signed [28:0] v_ext;
    logic signed [28:0] neg_lim;
    logic signed [28:0] pos_lim;
    logic               neg_over;
    logic               pos_over;

    // Limits: 10^(w-2) with a sign column, else 10^(w-1); upper bound ten times that.
    always_comb
    begin
        lim_exp  = cfg.has_sign ? (cfg.width - 4'd2) : (cfg.width - 4'd1);
        lim      = pow10(lim_exp);
        hi       = pow10(lim_exp + 4'd1);
        v_ext    = 29'(signed'(value));
        neg_lim  = -signed'({1'b0, lim});
        pos_lim  = signed'({1'b0, hi});
        neg_over = (v_ext <= neg_lim);
        pos_over = (v_ext >= pos_lim);
    end

    // Build the queue item; the magnitude of -32768 fits in 16 unsigned bits.
    always_comb
    begin
        entry.neg = value[15];
        entry.mag = value[15] ? (~value + 16'd1) : value;
        if (neg_over)
        begin
            entry.cls = CLS_NEG_OVER;
        end
        else if (pos_over)
        begin
            entry.cls = CLS_POS_OVER;
        end
        else
        begin
            entry.cls = CLS_NORMAL;
        end
        push = in_valid && !q_full;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sdf_queue.sv =====
// ----------------------------------------------------------------------------
// sdf_queue - two-entry item queue
// Decouples the classifying front from the character-generating back.
// ----------------------------------------------------------------------------
`default_nettype none

module sdf_queue
    import sdf_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire entry_t push_entry,
    input  wire logic   pop,
    output logic        full,
    output logic        empty,
    output entry_t      head
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    entry_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push;
    logic               do_pop;

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // Storage array; payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sdf_back.sv =====
// ----------------------------------------------------------------------------
// sdf_back - digit conversion and character output
// Splits the magnitude into decimal digits, one per cycle, then sends the
// field left to right through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sdf_back
    import sdf_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire cfg_t   cfg,
    input  wire logic   q_empty,
    input  wire entry_t q_head,
    output logic        pop,
    output logic        out_valid,
    input  wire logic   out_stall,
    output logic [7:0]  character,
    output logic [2:0]  position,
    output logic        last
);

    state_t                 state_reg;
    state_t                 state_next;
    cls_t                   cls_reg;
    logic                   neg_reg;
    logic [15:0]            mag_reg;
    logic [3:0]             digit_reg [DIGITS];
    logic [DIGIT_IDXW-1:0]  ndig_reg;
    logic [2:0]             pos_reg;
    logic                   out_valid_reg;
    logic [7:0]             char_reg;
    logic [2:0]             opos_reg;
    logic                   olast_reg;

    logic [31:0]            prod;
    logic [15:0]            quot;
    logic [15:0]            rem_full;
    logic [3:0]             rem;
    logic                   load_out;
    logic [3:0]             col_from_right;
    logic                   is_digit;
    logic                   is_sign_col;
    logic [7:0]             char_next;
    logic                   last_next;

    assign out_valid = out_valid_reg;
    assign character = char_reg;
    assign position  = opos_reg;
    assign last      = olast_reg;

    // Divide by ten through the reciprocal, remainder by shift and add.
    always_comb
    begin
        prod     = mag_reg * 32'(RECIP_TEN);
        quot     = 16'(prod >> RECIP_SHIFT);
        rem_full = mag_reg - ((quot << 3) + (quot << 1));
        rem      = rem_full[3:0];
    end

    // Character for the current column, counted from the right for digits.
    always_comb
    begin
        col_from_right = cfg.width - 4'd1 - {1'b0, pos_reg};
        is_digit       = (col_from_right < {1'b0, ndig_reg});
        is_sign_col    = cfg.lead ? (pos_reg == 3'd0)
                                  : (col_from_right == {1'b0, ndig_reg});
        last_next      = ({1'b0, pos_reg} == (cfg.width - 4'd1));
        if (cls_reg == CLS_NEG_OVER)
        begin
            char_next = ASCII_MINUS;
        end
        else if (cls_reg == CLS_POS_OVER)
        begin
            char_next = ASCII_PLUS;
        end
        else if (is_digit)
        begin
            char_next = ASCII_ZERO + {4'd0, digit_reg[col_from_right[DIGIT_IDXW-1:0]]};
        end
        else if (cfg.has_sign && is_sign_col)
        begin
            if (neg_reg)
            begin
                char_next = ASCII_MINUS;
            end
            else if (cfg.plus)
            begin
                char_next = ASCII_PLUS;
            end
            else
            begin
                char_next = ASCII_SPACE;
            end
        end
        else if (cfg.lead)
        begin
            char_next = ASCII_ZERO;
        end
        else
        begin
            char_next = ASCII_SPACE;
        end
    end

    // Sequencer next state and strobes.
    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    pop        = 1'b1;
                    state_next = (q_head.cls == CLS_NORMAL) ? ST_CONVERT : ST_EMIT;
                end
            end
            ST_CONVERT:
            begin
                if (quot == 16'd0)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                load_out = !out_valid_reg || !out_stall;
                if (load_out && last_next)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers of the item in progress.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cls_reg  <= q_head.cls;
            neg_reg  <= q_head.neg;
            mag_reg  <= q_head.mag;
            ndig_reg <= '0;
            pos_reg  <= '0;
        end
        else if (state_reg == ST_CONVERT)
        begin
            digit_reg[ndig_reg] <= rem;
            ndig_reg            <= ndig_reg + DIGIT_IDXW'(1);
            mag_reg             <= quot;
        end
        else if (load_out)
        begin
            pos_reg <= pos_reg + 3'd1;
        end
        if (load_out)
        begin
            char_reg  <= char_next;
            opos_reg  <= pos_reg;
            olast_reg <= last_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/signed_decimal_field_formatter.sv =====
// ----------------------------------------------------------------------------
// signed_decimal_field_formatter - signed value to right-aligned ASCII field
// Top level: configuration registers, classifying front, item queue and
// the digit-converting back end.
// ----------------------------------------------------------------------------
// Usage:
// A signed 16-bit value enters on in_valid/value and is accepted when
// in_stall is low. Each item produces field_width characters on
// character/position/last, left to right, last set on the rightmost one.
// The front classifies an item in the cycle it is accepted and places it
// in a two-entry queue, so in_stall rises only when that queue is full.
// The back takes one item from the queue, works out its decimal digits
// (one to five) in a reciprocal divide-by-ten unit, then sends the
// characters through the output register; overflowing values skip the
// digit loop.
// While out_stall is high the output register holds and the back waits;
// the queue keeps taking items until it fills.
// Reset clears the queue and sequencer and loads width 3, no sign, space
// padding. Registers are to be written over the APB port only while the
// block is idle; the user is bound to this, the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_decimal_field_formatter
    import sdf_pkg::*;
#(
    parameter int MAX_WIDTH = 8
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [15:0] value,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       character,
    output logic [2:0]       position,
    output logic             last
);

    localparam logic [3:0] MAX_W = 4'(MAX_WIDTH);

    logic [3:0]  field_width_reg;
    logic [1:0]  sign_mode_reg;
    logic        leading_zeros_reg;
    logic [1:0]  reg_idx;
    logic        wr_en;
    cfg_t        cfg;
    logic        push;
    entry_t      push_entry;
    logic        q_full;
    logic        q_empty;
    logic        pop;
    entry_t      q_head;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready && (paddr[1:0] == 2'd0 || 1'b1);

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_width_reg   <= 4'd3;
            sign_mode_reg     <= SIGN_NONE;
            leading_zeros_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_FIELD_WIDTH:   field_width_reg   <= pwdata[3:0];
                REG_SIGN_MODE:     sign_mode_reg     <= pwdata[1:0];
                REG_LEADING_ZEROS: leading_zeros_reg <= pwdata[0];
                default:           ;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        unique case (reg_idx)
            REG_FIELD_WIDTH:   prdata = {28'd0, field_width_reg};
            REG_SIGN_MODE:     prdata = {30'd0, sign_mode_reg};
            REG_LEADING_ZEROS: prdata = {31'd0, leading_zeros_reg};
            default:           prdata = 32'd0;
        endcase
    end

    // Decode configuration; widths out of range are clamped.
    always_comb
    begin
        if (field_width_reg < 4'd2)
        begin
            cfg.width = 4'd2;
        end
        else if (field_width_reg > MAX_W)
        begin
            cfg.width = MAX_W;
        end
        else
        begin
            cfg.width = field_width_reg;
        end
        cfg.has_sign = (sign_mode_reg != SIGN_NONE);
        cfg.plus     = (sign_mode_reg >= SIGN_BOTH);
        cfg.lead     = leading_zeros_reg;
    end

    assign in_stall = q_full;

    sdf_front u_front (
        .cfg      (cfg),
        .in_valid (in_valid),
        .value    (value),
        .q_full   (q_full),
        .push     (push),
        .entry    (push_entry)
    );

    sdf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (q_full),
        .empty      (q_empty),
        .head       (q_head)
    );

    sdf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .character (character),
        .position  (position),
        .last      (last)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/sdf_checker.sv =====
// ----------------------------------------------------------------------------
// sdf_checker - port-level checks for the decimal field formatter
// Watches the output channel for column order and a held result.
// ----------------------------------------------------------------------------
`default_nettype none

module sdf_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [7:0] character,
    input wire logic [2:0] position,
    input wire logic       last
);

    // A stalled result stays in place.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(character) && $stable(position))
        else $error("stalled output item changed");

    // Columns of one field advance by one.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=> !out_valid || position == $past(position) + 3'd1)
        else $error("output column skipped");

    // A new field starts at the leftmost column.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && last |=> !out_valid || position == 3'd0)
        else $error("field did not restart at column zero");

    // A field is at least two characters wide.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> position != 3'd0)
        else $error("field ended at column zero");

endmodule

bind signed_decimal_field_formatter sdf_checker u_sdf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .character (character),
    .position  (position),
    .last      (last)
);

`default_nettype wire
